// File: hw/rtl/top_k_smallest_max_heap_macros.svh
// Assertion macros for the top-k smallest max-heap selector.
`ifndef TOP_K_SMALLEST_MAX_HEAP_MACROS_SVH
`define TOP_K_SMALLEST_MAX_HEAP_MACROS_SVH
`ifndef ASSERT_OFF
`define TKSMH_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
`define TKSMH_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define TKSMH_ASSERT_IMP(lbl, ante, cons, msg)
`define TKSMH_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: hw/rtl/tksmh_pkg.sv
// Shared constants, state encoding and control structs of the top-k selector.
`default_nettype none
package tksmh_pkg;
	localparam int MAX_KEEP = 16;
	localparam int DATA_W = 32;
	localparam int KEEP_W = 5;
	localparam int KEEP_RESET = 4;
	localparam int SEEN_W = $clog2(MAX_KEEP + 2);
	localparam int ADDR_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
	localparam int CHILD_W = SEEN_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UP_RD,
		ST_UP_CMP,
		ST_DN_RD,
		ST_DN_CMP,
		ST_FIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic up_rd;
		logic dn_rd;
		logic wr_hole;
		logic wr_up;
		logic wr_dn;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic insert;
		logic replace;
		logic up_top;
		logic up_move;
		logic dn_leaf;
		logic dn_move;
		logic emit_go;
		logic emit_end;
	} sts_t;
endpackage
`default_nettype wire

// File: hw/rtl/tksmh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module tksmh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// File: hw/rtl/tksmh_ctrl.sv
// Sequencer that steps the heap datapath through insert, sift and readout.
`default_nettype none
module tksmh_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire tksmh_pkg::sts_t sts,
	output tksmh_pkg::cmd_t     cmd,
	output logic                busy
);
	import tksmh_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					if (sts.insert) begin
						state_d = ST_UP_RD;
					end else if (sts.replace) begin
						state_d = ST_DN_RD;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_UP_RD: begin
				if (sts.up_top) begin
					cmd.wr_hole = 1'b1;
					state_d = ST_FIN;
				end else begin
					cmd.up_rd = 1'b1;
					state_d = ST_UP_CMP;
				end
			end
			ST_UP_CMP: begin
				if (sts.up_move) begin
					cmd.wr_up = 1'b1;
					state_d = ST_UP_RD;
				end else begin
					cmd.wr_hole = 1'b1;
					state_d = ST_FIN;
				end
			end
			ST_DN_RD: begin
				if (sts.dn_leaf) begin
					cmd.wr_hole = 1'b1;
					state_d = ST_FIN;
				end else begin
					cmd.dn_rd = 1'b1;
					state_d = ST_DN_CMP;
				end
			end
			ST_DN_CMP: begin
				if (sts.dn_move) begin
					cmd.wr_dn = 1'b1;
					state_d = ST_DN_RD;
				end else begin
					cmd.wr_hole = 1'b1;
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				state_d = sts.emit_go ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (sts.emit_end) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
endmodule
`default_nettype wire

// File: hw/rtl/tksmh_dp.sv
// Heap datapath: heap and arrival RAMs, sift registers, run counters and result stage.
`default_nettype none
module tksmh_dp (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire tksmh_pkg::cmd_t                       cmd,
	output tksmh_pkg::sts_t                            sts,
	input  wire logic signed [tksmh_pkg::DATA_W-1:0]   sample,
	input  wire logic                                  final_item,
	input  wire logic                                  cfg_we,
	input  wire logic        [tksmh_pkg::KEEP_W-1:0]   cfg_wdata,
	output logic                                       result_valid,
	output logic signed      [tksmh_pkg::DATA_W-1:0]   kept_value,
	output logic                                       end_of_run
);
	import tksmh_pkg::*;

	logic [KEEP_W-1:0]        keep_q;
	logic [SEEN_W-1:0]        seen_q;
	logic [SEEN_W-1:0]        run_keep_q;
	logic [SEEN_W-1:0]        cnt_q;
	logic [SEEN_W-1:0]        idx_q;
	logic                     src_arr_q;
	logic                     last_q;
	logic [ADDR_W-1:0]        pos_q;
	logic signed [DATA_W-1:0] hole_q;
	logic signed [DATA_W-1:0] root_q;
	logic                     emit_s1;
	logic                     end_s1;
	logic                     src_s1;

	logic [SEEN_W-1:0]  k_sat;
	logic [SEEN_W-1:0]  k_now;
	logic [SEEN_W-1:0]  seen_inc;
	logic [SEEN_W-1:0]  idx_next;
	logic [ADDR_W-1:0]  parent;
	logic [CHILD_W-1:0] left_c;
	logic [CHILD_W-1:0] right_c;
	logic [CHILD_W-1:0] size_c;
	logic               right_ok;
	logic               take_l;
	logic               take_r;
	logic signed [DATA_W-1:0] bigger;
	logic signed [DATA_W-1:0] rd_a_s;
	logic signed [DATA_W-1:0] rd_b_s;

	logic [DATA_W-1:0] heap_rd_a;
	logic [DATA_W-1:0] heap_rd_b;
	logic [DATA_W-1:0] arr_rd;
	logic              heap_we;
	logic [DATA_W-1:0] heap_wdata;
	logic [ADDR_W-1:0] heap_raddr_a;
	logic              arr_we;

	assign k_sat = (int'(keep_q) > MAX_KEEP) ? SEEN_W'(MAX_KEEP) : SEEN_W'(keep_q);
	assign k_now = (seen_q == '0) ? k_sat : run_keep_q;
	assign seen_inc = seen_q + ((seen_q <= k_now) ? SEEN_W'(1) : SEEN_W'(0));
	assign idx_next = idx_q + SEEN_W'(1);

	assign parent = (pos_q - ADDR_W'(1)) >> 1;
	assign left_c = (CHILD_W'(pos_q) << 1) + CHILD_W'(1);
	assign right_c = (CHILD_W'(pos_q) << 1) + CHILD_W'(2);
	assign size_c = CHILD_W'(run_keep_q);
	assign right_ok = (right_c < size_c);

	assign rd_a_s = $signed(heap_rd_a);
	assign rd_b_s = $signed(heap_rd_b);
	assign take_l = (hole_q < rd_a_s);
	assign bigger = take_l ? rd_a_s : hole_q;
	assign take_r = right_ok && (bigger < rd_b_s);

	assign sts.insert = (seen_q < k_now);
	assign sts.replace = (seen_q >= k_now) && (k_now != '0) && (sample < root_q);
	assign sts.up_top = (pos_q == '0);
	assign sts.up_move = (rd_a_s < hole_q);
	assign sts.dn_leaf = (left_c >= size_c);
	assign sts.dn_move = take_l || take_r;
	assign sts.emit_go = last_q && (cnt_q != '0);
	assign sts.emit_end = (idx_next == cnt_q);

	assign heap_we = cmd.wr_hole || cmd.wr_up || cmd.wr_dn;
	always_comb begin
		priority if (cmd.wr_up) begin
			heap_wdata = heap_rd_a;
		end else if (cmd.wr_dn) begin
			heap_wdata = take_r ? heap_rd_b : heap_rd_a;
		end else begin
			heap_wdata = hole_q;
		end
	end

	always_comb begin
		priority if (cmd.up_rd) begin
			heap_raddr_a = parent;
		end else if (cmd.dn_rd) begin
			heap_raddr_a = left_c[ADDR_W-1:0];
		end else begin
			heap_raddr_a = idx_q[ADDR_W-1:0];
		end
	end

	assign arr_we = cmd.accept && sts.insert;

	// Two mirrored copies of the heap give the two child reads of a sift-down level.
	tksmh_ram #(.WIDTH(DATA_W), .DEPTH(MAX_KEEP)) u_heap_a (
		.clk   (clk),
		.we    (heap_we),
		.waddr (pos_q),
		.wdata (heap_wdata),
		.raddr (heap_raddr_a),
		.rdata (heap_rd_a)
	);

	tksmh_ram #(.WIDTH(DATA_W), .DEPTH(MAX_KEEP)) u_heap_b (
		.clk   (clk),
		.we    (heap_we),
		.waddr (pos_q),
		.wdata (heap_wdata),
		.raddr (right_c[ADDR_W-1:0]),
		.rdata (heap_rd_b)
	);

	tksmh_ram #(.WIDTH(DATA_W), .DEPTH(MAX_KEEP)) u_arrival (
		.clk   (clk),
		.we    (arr_we),
		.waddr (seen_q[ADDR_W-1:0]),
		.wdata (sample),
		.raddr (idx_q[ADDR_W-1:0]),
		.rdata (arr_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= KEEP_W'(KEEP_RESET);
			seen_q <= '0;
			run_keep_q <= '0;
			last_q <= 1'b0;
			emit_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				keep_q <= cfg_wdata;
			end
			if (cmd.accept) begin
				run_keep_q <= k_now;
				last_q <= final_item;
				seen_q <= final_item ? '0 : seen_inc;
			end
			emit_s1 <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			hole_q <= sample;
			pos_q <= sts.insert ? seen_q[ADDR_W-1:0] : '0;
			cnt_q <= (seen_inc <= k_now) ? seen_inc : k_now;
			src_arr_q <= (seen_inc <= k_now);
			idx_q <= '0;
		end else begin
			if (cmd.wr_up) begin
				pos_q <= parent;
			end else if (cmd.wr_dn) begin
				pos_q <= take_r ? right_c[ADDR_W-1:0] : left_c[ADDR_W-1:0];
			end
			if (cmd.emit) begin
				idx_q <= idx_next;
			end
		end
		if (heap_we && (pos_q == '0)) begin
			root_q <= $signed(heap_wdata);
		end
		end_s1 <= sts.emit_end;
		src_s1 <= src_arr_q;
	end

	assign result_valid = emit_s1;
	assign kept_value = src_s1 ? $signed(arr_rd) : $signed(heap_rd_a);
	assign end_of_run = end_s1;
endmodule
`default_nettype wire

// File: hw/rtl/top_k_smallest_max_heap.sv
// Top level of the top-k smallest selector built on a binary max-heap.
`default_nettype none
`include "top_k_smallest_max_heap_macros.svh"
// Keeps the keep_count smallest signed samples of a run in a max-heap held in RAM.
// An item is taken when start is high and busy is low; busy stays high while
// the item is processed. An item that neither enters nor replaces the root
// goes straight to the finish state. An insert or a root replacement sifts
// it up or down the heap one level at a time: every level of a sift is a heap
// RAM read state and then a compare-and-write state, and the sift ends at the
// root, at a leaf or when a compare stops it. On the final item busy stays
// high while the retained values are read out, and they follow on
// result_valid, one per cycle in consecutive cycles, with end_of_run on the
// last; the receiver cannot stall them, so it must take each result in the
// cycle it is shown. keep_count is latched at the first item of a run and
// saturates at 16.
module top_k_smallest_max_heap (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic signed [tksmh_pkg::DATA_W-1:0] sample,
	input  wire logic                                final_item,
	input  wire logic                                cfg_we,
	input  wire logic        [tksmh_pkg::KEEP_W-1:0] cfg_wdata,
	output logic                                     result_valid,
	output logic signed      [tksmh_pkg::DATA_W-1:0] kept_value,
	output logic                                     end_of_run
);
	import tksmh_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tksmh_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	tksmh_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.sample       (sample),
		.final_item   (final_item),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.kept_value   (kept_value),
		.end_of_run   (end_of_run)
	);

	`TKSMH_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
	`TKSMH_ASSERT_NXT(a_run_stream, result_valid && !end_of_run, result_valid, "result stream broke")
	`TKSMH_ASSERT_NXT(a_run_end, result_valid && end_of_run, !result_valid, "result after end of run")
	`TKSMH_ASSERT_IMP(a_idle_nowrite, !busy, !(cmd.wr_hole || cmd.wr_up || cmd.wr_dn), "heap write while idle")
endmodule
`default_nettype wire
